@@ hdl/lkv_pkg.sv @@
// ----------------------------------------------------------------------------
// lkv_pkg
// shared types, constants and helpers for the lru key/value cache core
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int KEY_BITS        = 32;
    localparam int WORD_W          = 32;
    localparam int CAP_W           = 5;
    localparam int CAP_DEFAULT     = 16;
    localparam int CMD_W           = 1;

    localparam int IN_DATA_W  = 2 * WORD_W;
    localparam int OUT_DATA_W = ((2 * WORD_W + 2 + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - 2 * WORD_W - 2;

    localparam logic [WORD_W-1:0] MISS_VALUE = '1;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic entry_we;
        logic data_we;
        logic rank_we;
    } store_ctl_t;

    typedef struct packed {
        logic ok;
        logic valid;
    } store_stat_t;

    function automatic int idx_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

@@ hdl/lru_key_value_cache_core.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// fully associative key/value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
// Each beat is a get or a put. The core scans all MAX_ENTRIES slots one per
// cycle through a single read port on the entry memories and one key
// comparator, then decides and walks the slots again to rewrite the recency
// ranks. A get that misses skips the rank pass. The input is not ready while
// a command is at work. The result sits in an output register, so a new
// command is taken while it waits. The store is empty after reset, with no
// clearing pass. Capacity writes are taken only while the store is empty;
// other writes are dropped.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core #(
    parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // key [31:0], value [63:32]
    input  logic [lkv_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // command [0]
    input  logic [lkv_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // hit [0], read_value [32:1], evicted [33], evicted_key [65:34], zero pad
    output logic [lkv_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0]        cfg_data
);
    import lkv_pkg::*;

    localparam int IDX_W    = idx_bits(MAX_ENTRIES);
    localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
    localparam int CW       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int CMP_BITS = (KEY_BITS < WORD_W) ? KEY_BITS : WORD_W;

    localparam logic [CAP_W-1:0] CAP_RESET =
        CAP_W'((CAP_DEFAULT > MAX_ENTRIES) ? MAX_ENTRIES : CAP_DEFAULT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(MAX_ENTRIES);

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [CNT_W-1:0]  occ_reg;
    logic [CNT_W-1:0]  occ_next;
    logic [CAP_W-1:0]  cap_reg;
    logic [CAP_W-1:0]  cap_next;

    logic              cmd_reg;
    logic [WORD_W-1:0] key_reg;
    logic [WORD_W-1:0] val_reg;

    logic              found_reg;
    logic [IDX_W-1:0]  slot_reg;
    logic [IDX_W-1:0]  old_rank_reg;
    logic [WORD_W-1:0] hit_data_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_slot_reg;
    logic              worst_found_reg;
    logic [IDX_W-1:0]  worst_slot_reg;
    logic [IDX_W-1:0]  worst_rank_reg;
    logic [WORD_W-1:0] worst_key_reg;

    logic [IDX_W-1:0]  upd_slot_reg;
    logic              insert_reg;

    logic              pend_hit_reg;
    logic [WORD_W-1:0] pend_value_reg;
    logic              pend_evicted_reg;
    logic [WORD_W-1:0] pend_evkey_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    store_ctl_t        ctl;
    store_stat_t       rd_stat;
    logic [IDX_W-1:0]  rd_idx;
    logic [WORD_W-1:0] rd_key;
    logic [WORD_W-1:0] rd_data;
    logic [IDX_W-1:0]  rd_rank;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  wr_rank;

    logic              accept;
    logic              last_rsp;
    logic              scan_rsp;
    logic              key_match;
    logic              hit_take;
    logic              free_take;
    logic              worst_take;
    logic              is_full;
    logic              out_free;
    logic              issue;
    logic [IDX_W-1:0]  dec_slot;

    lkv_store #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .rd_addr (cnt_reg[IDX_W-1:0]),
        .wr_addr (wr_addr),
        .wr_key  (key_reg),
        .wr_data (val_reg),
        .wr_rank (wr_rank),
        .rd_stat (rd_stat),
        .rd_idx  (rd_idx),
        .rd_key  (rd_key),
        .rd_data (rd_data),
        .rd_rank (rd_rank)
    );

    // compare unit and scan trackers
    always_comb
    begin
        accept     = s_axis_tvalid && s_axis_tready;
        last_rsp   = rd_stat.ok && (rd_idx == LAST_IDX);
        scan_rsp   = (state_reg == ST_SCAN) && rd_stat.ok;
        key_match  = rd_stat.valid && (rd_key[CMP_BITS-1:0] == key_reg[CMP_BITS-1:0]);
        hit_take   = scan_rsp && key_match && !found_reg;
        free_take  = scan_rsp && !rd_stat.valid && !free_found_reg;
        worst_take = scan_rsp && rd_stat.valid
                     && (!worst_found_reg || (rd_rank > worst_rank_reg));
        is_full    = CW'(occ_reg) >= CW'(cap_reg);
        out_free   = !out_valid_reg || m_axis_tready;
        issue      = cnt_reg < CNT_END;
        if (found_reg)
        begin
            dec_slot = slot_reg;
        end
        else if (is_full)
        begin
            dec_slot = worst_slot_reg;
        end
        else
        begin
            dec_slot = free_slot_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_rsp)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if ((cmd_reg == CMD_GET) && !found_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (last_rsp)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        ctl           = '0;
        wr_addr       = rd_idx;
        wr_rank       = rd_rank + IDX_W'(1);
        s_axis_tready = 1'b0;
        cnt_next      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_SCAN:
            begin
                ctl.rd_en = issue;
                cnt_next  = issue ? cnt_reg + CNT_W'(1) : cnt_reg;
            end
            ST_DECIDE:
            begin
                ctl.entry_we = (cmd_reg == CMD_PUT) && !found_reg;
                ctl.data_we  = (cmd_reg == CMD_PUT);
                wr_addr      = dec_slot;
            end
            ST_UPDATE:
            begin
                ctl.rd_en = issue;
                cnt_next  = issue ? cnt_reg + CNT_W'(1) : cnt_reg;
                if (rd_stat.ok)
                begin
                    if (rd_idx == upd_slot_reg)
                    begin
                        ctl.rank_we = 1'b1;
                        wr_rank     = '0;
                    end
                    else if (rd_stat.valid && (insert_reg || (rd_rank < old_rank_reg)))
                    begin
                        ctl.rank_we = 1'b1;
                    end
                end
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    // capacity and occupancy
    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_valid && (occ_reg == '0))
        begin
            if (cfg_data == '0)
            begin
                cap_next = CAP_W'(1);
            end
            else if (CW'(cfg_data) > CW'(MAX_ENTRIES))
            begin
                cap_next = CAP_W'(MAX_ENTRIES);
            end
            else
            begin
                cap_next = cfg_data;
            end
        end
        occ_next = occ_reg;
        if ((state_reg == ST_DECIDE) && (cmd_reg == CMD_PUT) && !found_reg && !is_full)
        begin
            occ_next = occ_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            occ_reg         <= '0;
            cap_reg         <= CAP_RESET;
            found_reg       <= 1'b0;
            free_found_reg  <= 1'b0;
            worst_found_reg <= 1'b0;
            insert_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            occ_reg   <= occ_next;
            cap_reg   <= cap_next;
            if (accept)
            begin
                found_reg       <= 1'b0;
                free_found_reg  <= 1'b0;
                worst_found_reg <= 1'b0;
            end
            else
            begin
                if (hit_take)
                begin
                    found_reg <= 1'b1;
                end
                if (free_take)
                begin
                    free_found_reg <= 1'b1;
                end
                if (worst_take)
                begin
                    worst_found_reg <= 1'b1;
                end
            end
            if (state_reg == ST_DECIDE)
            begin
                insert_reg <= !found_reg;
            end
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= s_axis_tuser[0];
            key_reg <= s_axis_tdata[WORD_W-1:0];
            val_reg <= s_axis_tdata[2*WORD_W-1:WORD_W];
        end
        if (hit_take)
        begin
            slot_reg     <= rd_idx;
            old_rank_reg <= rd_rank;
            hit_data_reg <= rd_data;
        end
        if (free_take)
        begin
            free_slot_reg <= rd_idx;
        end
        if (worst_take)
        begin
            worst_slot_reg <= rd_idx;
            worst_rank_reg <= rd_rank;
            worst_key_reg  <= rd_key;
        end
        if (state_reg == ST_DECIDE)
        begin
            upd_slot_reg     <= dec_slot;
            pend_hit_reg     <= found_reg;
            pend_value_reg   <= '0;
            pend_evicted_reg <= 1'b0;
            pend_evkey_reg   <= '0;
            if (cmd_reg == CMD_GET)
            begin
                pend_value_reg <= found_reg ? hit_data_reg : MISS_VALUE;
            end
            else if (!found_reg && is_full)
            begin
                pend_evicted_reg <= 1'b1;
                pend_evkey_reg   <= worst_key_reg;
            end
        end
        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_data_reg <= {{OUT_PAD_W{1'b0}}, pend_evkey_reg, pend_evicted_reg,
                             pend_value_reg, pend_hit_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(occ_reg) <= CW'(cap_reg))
        else $error("occupancy above capacity");

    a_evict_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[WORD_W+1]) |-> !out_data_reg[0])
        else $error("eviction reported on a hit");

    a_rsp_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        rd_stat.ok |-> ((state_reg == ST_SCAN) || (state_reg == ST_UPDATE)))
        else $error("memory read returned outside a scan pass");

endmodule

@@ hdl/lkv_store.sv @@
// ----------------------------------------------------------------------------
// lkv_store
// entry storage: key, data and rank memories with one registered read port
// each, plus per-entry valid flags
// ----------------------------------------------------------------------------
module lkv_store #(
    parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  lkv_pkg::store_ctl_t                           ctl,
    input  logic [lkv_pkg::idx_bits(MAX_ENTRIES)-1:0]     rd_addr,
    input  logic [lkv_pkg::idx_bits(MAX_ENTRIES)-1:0]     wr_addr,
    input  logic [lkv_pkg::WORD_W-1:0]                    wr_key,
    input  logic [lkv_pkg::WORD_W-1:0]                    wr_data,
    input  logic [lkv_pkg::idx_bits(MAX_ENTRIES)-1:0]     wr_rank,
    output lkv_pkg::store_stat_t                          rd_stat,
    output logic [lkv_pkg::idx_bits(MAX_ENTRIES)-1:0]     rd_idx,
    output logic [lkv_pkg::WORD_W-1:0]                    rd_key,
    output logic [lkv_pkg::WORD_W-1:0]                    rd_data,
    output logic [lkv_pkg::idx_bits(MAX_ENTRIES)-1:0]     rd_rank
);
    import lkv_pkg::*;

    localparam int IDX_W = idx_bits(MAX_ENTRIES);

    logic [WORD_W-1:0]      key_mem  [MAX_ENTRIES];
    logic [WORD_W-1:0]      data_mem [MAX_ENTRIES];
    logic [IDX_W-1:0]       rank_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.entry_we)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (ctl.rd_en)
        begin
            rd_key <= key_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.data_we)
        begin
            data_mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data <= data_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rank_we)
        begin
            rank_mem[wr_addr] <= wr_rank;
        end
        if (ctl.rd_en)
        begin
            rd_rank <= rank_mem[rd_addr];
            rd_idx  <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rd_stat.ok    <= 1'b0;
            rd_stat.valid <= 1'b0;
        end
        else
        begin
            if (ctl.entry_we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_stat.ok <= ctl.rd_en;
            if (ctl.rd_en)
            begin
                rd_stat.valid <= valid_reg[rd_addr];
            end
        end
    end

endmodule
